### hw/rtl/string_slot_ring_fifo_unit_macros.svh
// Assertion macros for the string slot ring FIFO.
// Depends on nothing; included by the modules that carry assertions.
`ifndef STRING_SLOT_RING_FIFO_UNIT_MACROS_SVH
`define STRING_SLOT_RING_FIFO_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SSRF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssrf assertion failed");

// Next-cycle implication, disabled during reset.
`define SSRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssrf assertion failed");

`endif

### hw/rtl/ssrf_pkg.sv
// Package of the string slot ring FIFO: sizes, codes, structs and helpers.
// Depends on nothing.
package ssrf_pkg;

  localparam int SLOTS       = 16;
  localparam int SLOT_BYTES  = 256;
  localparam int IDX_W       = $clog2(SLOTS);
  localparam int POS_W       = $clog2(SLOT_BYTES);
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int BADDR_W     = IDX_W + POS_W;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 8;
  localparam int CAP_W       = 5;
  localparam int STAT_W      = 2;
  localparam int TOTAL_W     = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CAP_W-1:0] CAP_RESET    = CAP_W'(10);
  localparam logic [LEN_W-1:0] MAXLEN_RESET = LEN_W'(255);
  localparam logic [BYTE_W-1:0] NUL_BYTE    = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY = 1'b0,
    CFG_MAX_LEN  = 1'b1
  } cfg_reg_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_POP  = 1'b1
  } mode_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_BUSY = 1'b1
  } state_t;

  typedef struct packed {
    logic              mode;
    logic [BYTE_W-1:0] data;
    logic              eos;
  } item_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [BYTE_W-1:0]  data_out;
    logic               last_byte;
    logic [CNT_W-1:0]   fill_count;
    logic [TOTAL_W-1:0] produced_total;
  } result_t;

  typedef struct packed {
    logic               byte_we;
    logic [BADDR_W-1:0] byte_waddr;
    logic [BYTE_W-1:0]  byte_wdata;
    logic [BADDR_W-1:0] byte_raddr;
    logic               len_we;
    logic [IDX_W-1:0]   len_waddr;
    logic [LEN_W-1:0]   len_wdata;
    logic [IDX_W-1:0]   len_raddr;
  } mem_req_t;

  function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (c == '0) begin
      r = CNT_W'(1);
    end else if (CNT_W'(c) > CNT_W'(SLOTS)) begin
      r = CNT_W'(SLOTS);
    end else begin
      r = CNT_W'(c);
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] n;
    n = CNT_W'(idx) + CNT_W'(1);
    return (n >= cap) ? '0 : n[IDX_W-1:0];
  endfunction

endpackage

### hw/rtl/ssrf_in_if.sv
// Request channel of the string slot ring FIFO: valid/ready and one byte op.
// Depends on ssrf_pkg.
interface ssrf_in_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [ssrf_pkg::BYTE_W-1:0] data_in;
  logic                       end_of_string;

  modport source (output valid, mode, data_in, end_of_string, input ready);
  modport sink   (input valid, mode, data_in, end_of_string, output ready);
endinterface

### hw/rtl/ssrf_out_if.sv
// Result channel of the string slot ring FIFO: valid/ready and one result.
// Depends on ssrf_pkg.
interface ssrf_out_if;
  logic                         valid;
  logic                         ready;
  logic [ssrf_pkg::STAT_W-1:0]  status;
  logic [ssrf_pkg::BYTE_W-1:0]  data_out;
  logic                         last_byte;
  logic [ssrf_pkg::CNT_W-1:0]   fill_count;
  logic [ssrf_pkg::TOTAL_W-1:0] produced_total;

  modport source (output valid, status, data_out, last_byte, fill_count, produced_total,
                  input ready);
  modport sink   (input valid, status, data_out, last_byte, fill_count, produced_total,
                  output ready);
endinterface

### hw/rtl/ssrf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module ssrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/ssrf_ctrl.sv
// Pointer and counter state of the string slot ring FIFO, and the
// read-modify-write step over the slot memories. Depends on ssrf_pkg.
`include "string_slot_ring_fifo_unit_macros.svh"

module ssrf_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            commit_i,
  input  ssrf_pkg::item_t                 item_i,
  input  logic [ssrf_pkg::CAP_W-1:0]      capacity_i,
  input  logic [ssrf_pkg::LEN_W-1:0]      max_len_i,
  input  logic [ssrf_pkg::BYTE_W-1:0]     byte_rdata_i,
  input  logic [ssrf_pkg::LEN_W-1:0]      len_rdata_i,
  output ssrf_pkg::mem_req_t              mem_o,
  output ssrf_pkg::result_t               res_o
);

  logic [ssrf_pkg::IDX_W-1:0]   tail_r, tail_nxt;
  logic [ssrf_pkg::IDX_W-1:0]   head_r, head_nxt;
  logic [ssrf_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [ssrf_pkg::POS_W-1:0]   wpos_r, wpos_nxt;
  logic                         ended_r, ended_nxt;
  logic [ssrf_pkg::POS_W-1:0]   rpos_r, rpos_nxt;
  logic [ssrf_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic [ssrf_pkg::CNT_W-1:0]   cap;

  assign cap = ssrf_pkg::eff_cap(capacity_i);

  always_comb begin
    tail_nxt  = tail_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    wpos_nxt  = wpos_r;
    ended_nxt = ended_r;
    rpos_nxt  = rpos_r;
    total_nxt = total_r;

    mem_o            = '0;
    mem_o.byte_raddr = {head_r, rpos_r};
    mem_o.len_raddr  = head_r;
    mem_o.byte_waddr = {tail_r, wpos_r};
    mem_o.byte_wdata = item_i.data;
    mem_o.len_waddr  = tail_r;

    res_o        = '0;
    res_o.status = ssrf_pkg::ST_OK;

    if (item_i.mode == ssrf_pkg::MODE_PUSH) begin
      if (count_r >= cap) begin
        res_o.status = ssrf_pkg::ST_FULL;
      end else begin
        if (item_i.data == ssrf_pkg::NUL_BYTE) begin
          ended_nxt = 1'b1;
        end else if (!ended_r && (wpos_r < max_len_i)) begin
          mem_o.byte_we = commit_i;
          wpos_nxt      = wpos_r + ssrf_pkg::POS_W'(1);
        end
        if (item_i.eos) begin
          mem_o.len_we    = commit_i;
          mem_o.len_wdata = ssrf_pkg::LEN_W'(wpos_nxt);
          tail_nxt        = ssrf_pkg::advance(tail_r, cap);
          count_nxt       = count_r + ssrf_pkg::CNT_W'(1);
          total_nxt       = total_r + ssrf_pkg::TOTAL_W'(1);
          wpos_nxt        = '0;
          ended_nxt       = 1'b0;
        end
      end
    end else begin
      if (count_r == '0) begin
        res_o.status = ssrf_pkg::ST_EMPTY;
      end else begin
        if (ssrf_pkg::LEN_W'(rpos_r) < len_rdata_i) begin
          res_o.data_out = byte_rdata_i;
          rpos_nxt       = rpos_r + ssrf_pkg::POS_W'(1);
        end
        if (ssrf_pkg::LEN_W'(rpos_nxt) >= len_rdata_i) begin
          res_o.last_byte = 1'b1;
          rpos_nxt        = '0;
          head_nxt        = ssrf_pkg::advance(head_r, cap);
          count_nxt       = count_r - ssrf_pkg::CNT_W'(1);
        end
      end
    end

    res_o.fill_count     = count_nxt;
    res_o.produced_total = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_r  <= '0;
      head_r  <= '0;
      count_r <= '0;
      wpos_r  <= '0;
      ended_r <= 1'b0;
      rpos_r  <= '0;
      total_r <= '0;
    end else if (commit_i) begin
      tail_r  <= tail_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      wpos_r  <= wpos_nxt;
      ended_r <= ended_nxt;
      rpos_r  <= rpos_nxt;
      total_r <= total_nxt;
    end
  end

  `SSRF_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= ssrf_pkg::CNT_W'(ssrf_pkg::SLOTS))
  `SSRF_ASSERT_NEXT(a_hold_idle, clk, rst_n, !commit_i, $stable(count_r) && $stable(head_r) && $stable(tail_r))
  `SSRF_ASSERT_NEXT(a_full_keeps, clk, rst_n, commit_i && res_o.status == ssrf_pkg::ST_FULL, $stable(wpos_r) && $stable(total_r))
  `SSRF_ASSERT_NOW(a_last_ok, clk, rst_n, res_o.last_byte, res_o.status == ssrf_pkg::ST_OK && !mem_o.byte_we && !mem_o.len_we)

endmodule

### hw/rtl/string_slot_ring_fifo_unit.sv
// String slot ring FIFO, top level.
// Usage:
//   in_req carries one byte operation per request: mode 0 pushes data_in into
//   the tail slot (a zero byte ends the string, bytes past max_len drop,
//   end_of_string commits the slot); mode 1 pops one byte of the head string.
//   out_res returns one result per request: status, popped byte, last_byte,
//   fill count and the running commit total.
//   cfg_we/cfg_index/cfg_data write capacity (index 0) and max_len (index 1);
//   write them only while no request is in flight.
// Timing:
//   A request is accepted in S_IDLE: the accept edge registers it and reads the
//   slot byte and length memories. In S_BUSY the commit edge writes back and
//   loads the result register, waiting while a stalled result still fills it.
//   A new request is accepted only after the previous one has committed.
// Reset: pointers, counters and the commit total clear; slot memories are not
//   cleared and need no clearing pass. When out_res stalls, one finished result
//   waits in the output register and one more request may be accepted and held.
// Depends on ssrf_pkg, ssrf_in_if, ssrf_out_if, ssrf_ram, ssrf_ctrl.
module string_slot_ring_fifo_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  ssrf_in_if.sink                            in_req,
  ssrf_out_if.source                         out_res,
  input  logic                               cfg_we,
  input  logic [ssrf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ssrf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  ssrf_pkg::state_t              state_r, state_nxt;
  ssrf_pkg::item_t               item_r;
  ssrf_pkg::result_t             res_r, res;
  ssrf_pkg::mem_req_t            mem;
  logic                          out_valid_r, out_valid_nxt;
  logic [ssrf_pkg::CAP_W-1:0]    capacity_r;
  logic [ssrf_pkg::LEN_W-1:0]    max_len_r;
  logic [ssrf_pkg::BYTE_W-1:0]   byte_rdata;
  logic [ssrf_pkg::LEN_W-1:0]    len_rdata;
  logic                          accept;
  logic                          commit;

  assign in_req.ready = (state_r == ssrf_pkg::S_IDLE);
  assign accept       = in_req.valid && in_req.ready;

  always_comb begin
    state_nxt     = state_r;
    commit        = 1'b0;
    out_valid_nxt = out_valid_r && !out_res.ready;
    case (state_r)
      ssrf_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = ssrf_pkg::S_BUSY;
        end
      end
      ssrf_pkg::S_BUSY: begin
        if (!out_valid_r || out_res.ready) begin
          commit        = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ssrf_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ssrf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssrf_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      capacity_r  <= ssrf_pkg::CAP_RESET;
      max_len_r   <= ssrf_pkg::MAXLEN_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          ssrf_pkg::CFG_CAPACITY: capacity_r <= cfg_data[ssrf_pkg::CAP_W-1:0];
          ssrf_pkg::CFG_MAX_LEN:  max_len_r  <= cfg_data[ssrf_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.mode <= in_req.mode;
      item_r.data <= in_req.data_in;
      item_r.eos  <= in_req.end_of_string;
    end
    if (commit) begin
      res_r <= res;
    end
  end

  ssrf_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .commit_i     (commit),
    .item_i       (item_r),
    .capacity_i   (capacity_r),
    .max_len_i    (max_len_r),
    .byte_rdata_i (byte_rdata),
    .len_rdata_i  (len_rdata),
    .mem_o        (mem),
    .res_o        (res)
  );

  ssrf_ram #(
    .WIDTH (ssrf_pkg::BYTE_W),
    .DEPTH (ssrf_pkg::SLOTS * ssrf_pkg::SLOT_BYTES)
  ) u_byte_ram (
    .clk   (clk),
    .we    (mem.byte_we),
    .waddr (mem.byte_waddr),
    .wdata (mem.byte_wdata),
    .raddr (mem.byte_raddr),
    .rdata (byte_rdata)
  );

  ssrf_ram #(
    .WIDTH (ssrf_pkg::LEN_W),
    .DEPTH (ssrf_pkg::SLOTS)
  ) u_len_ram (
    .clk   (clk),
    .we    (mem.len_we),
    .waddr (mem.len_waddr),
    .wdata (mem.len_wdata),
    .raddr (mem.len_raddr),
    .rdata (len_rdata)
  );

  assign out_res.valid          = out_valid_r;
  assign out_res.status         = res_r.status;
  assign out_res.data_out       = res_r.data_out;
  assign out_res.last_byte      = res_r.last_byte;
  assign out_res.fill_count     = res_r.fill_count;
  assign out_res.produced_total = res_r.produced_total;

endmodule

### sim/tb_string_slot_ring_fifo_unit.sv
`timescale 1ns / 1ps
// Testbench of string_slot_ring_fifo_unit: random byte push/pop requests under
// sender gaps and receiver stalls, each result checked against a ring model.
// Depends on ssrf_pkg, ssrf_in_if, ssrf_out_if and the RTL of the block.
module tb_string_slot_ring_fifo_unit;
  import ssrf_pkg::*;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_CAPACITY;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  ssrf_in_if  in_ch ();
  ssrf_out_if out_ch ();

  string_slot_ring_fifo_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_ch),
    .out_res   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  logic [BYTE_W-1:0]  slot_mem [SLOTS*SLOT_BYTES];
  int unsigned        slot_len [SLOTS];
  int unsigned        tail_q, head_q, count_q, wpos_q, rpos_q;
  bit                 ended_q;
  logic [TOTAL_W-1:0] commits_q;
  logic [CAP_W-1:0]   cap_q;
  logic [LEN_W-1:0]   maxlen_q;

  item_t   pending_items[$];
  result_t expected_results[$];
  int      fail_count;
  int      tx_idle_pct;
  int      rx_stall_pct;
  bit      rx_hold;

  function automatic int unsigned ring_cap();
    int unsigned c;
    c = cap_q;
    if (c == 0) c = 1;
    if (c > SLOTS) c = SLOTS;
    return c;
  endfunction

  function automatic int unsigned next_slot(input int unsigned idx);
    int unsigned n;
    n = idx + 1;
    if (n >= ring_cap() || n >= SLOTS) n = 0;
    return n;
  endfunction

  function automatic result_t fifo_step(input item_t it);
    result_t     r;
    int unsigned t;
    int unsigned h;
    r = '0;
    if (it.mode == MODE_PUSH) begin
      if (count_q >= ring_cap()) begin
        r.status = ST_FULL;
      end else begin
        t = tail_q % SLOTS;
        if (it.data == NUL_BYTE) begin
          ended_q = 1'b1;
        end else if (!ended_q && wpos_q < maxlen_q) begin
          slot_mem[t*SLOT_BYTES + wpos_q] = it.data;
          wpos_q++;
        end
        if (it.eos) begin
          slot_len[t] = wpos_q;
          tail_q      = next_slot(t);
          count_q     = (count_q + 1) & 32'h1f;
          commits_q   = commits_q + 1'b1;
          wpos_q      = 0;
          ended_q     = 1'b0;
        end
      end
    end else begin
      if (count_q == 0) begin
        r.status = ST_EMPTY;
      end else begin
        h = head_q % SLOTS;
        if (rpos_q < slot_len[h] && rpos_q < SLOT_BYTES) begin
          r.data_out = slot_mem[h*SLOT_BYTES + rpos_q];
          rpos_q++;
        end
        if (rpos_q >= slot_len[h]) begin
          r.last_byte = 1'b1;
          rpos_q      = 0;
          head_q      = next_slot(h);
          count_q--;
        end
      end
    end
    r.fill_count     = CNT_W'(count_q);
    r.produced_total = commits_q;
    return r;
  endfunction

  always @(posedge clk) begin : drive_requests
    item_t cur;
    item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        cur.mode = in_ch.mode;
        cur.data = in_ch.data_in;
        cur.eos  = in_ch.end_of_string;
        expected_results.push_back(fifo_step(cur));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = pending_items.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.mode          <= nxt.mode;
          in_ch.data_in       <= nxt.data;
          in_ch.end_of_string <= nxt.eos;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d data %0h",
                   $time, out_ch.status, out_ch.data_out);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_ch.status);
            fail_count++;
          end
          if (out_ch.data_out !== want.data_out) begin
            $display("%0t: data_out expected %0h actual %0h",
                     $time, want.data_out, out_ch.data_out);
            fail_count++;
          end
          if (out_ch.last_byte !== want.last_byte) begin
            $display("%0t: last_byte expected %0b actual %0b",
                     $time, want.last_byte, out_ch.last_byte);
            fail_count++;
          end
          if (out_ch.fill_count !== want.fill_count) begin
            $display("%0t: fill_count expected %0d actual %0d",
                     $time, want.fill_count, out_ch.fill_count);
            fail_count++;
          end
          if (out_ch.produced_total !== want.produced_total) begin
            $display("%0t: produced_total expected %0d actual %0d",
                     $time, want.produced_total, out_ch.produced_total);
            fail_count++;
          end
        end
      end
      out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic add_push(input logic [BYTE_W-1:0] d, input bit e);
    pending_items.push_back('{mode: MODE_PUSH, data: d, eos: e});
  endtask

  task automatic add_pops(input int n);
    repeat (n) pending_items.push_back('{mode: MODE_POP, data: '0, eos: 1'b0});
  endtask

  task automatic add_string(input int len, input bit with_nul);
    logic [BYTE_W-1:0] d;
    for (int i = 0; i < len; i++) begin
      d = BYTE_W'($urandom_range(255, 1));
      if (with_nul && $urandom_range(15) == 0) d = NUL_BYTE;
      add_push(d, i == len - 1);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Empty the ring so that a capacity change never strands a committed slot.
  task automatic drain_ring();
    int unsigned n;
    int unsigned h;
    wait_drained();
    n = 0;
    h = head_q % SLOTS;
    for (int unsigned k = 0; k < count_q; k++) begin
      n += (slot_len[h] == 0) ? 1 : slot_len[h];
      h = next_slot(h);
    end
    n -= rpos_q;
    add_pops(n);
    wait_drained();
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CAPACITY) cap_q = v[CAP_W-1:0];
    else maxlen_q = v[LEN_W-1:0];
    @(negedge clk);
  endtask

  task automatic set_ring(input logic [CFG_DATA_W-1:0] cap,
                          input logic [CFG_DATA_W-1:0] maxlen);
    drain_ring();
    write_reg(CFG_CAPACITY, cap);
    write_reg(CFG_MAX_LEN, maxlen);
  endtask

  // Mostly whole strings and pop bursts; the rest is raw noise.
  task automatic random_phase(input int n_items);
    int made;
    int pick;
    int len;
    made = 0;
    while (made < n_items) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(300, 1) : $urandom_range(12, 1);
        add_string(len, $urandom_range(7) == 0);
        made += len;
      end else if (pick < 90) begin
        len = $urandom_range(40, 1);
        add_pops(len);
        made += len;
      end else begin
        pending_items.push_back('{mode: 1'($urandom_range(1)),
                                  data: BYTE_W'($urandom_range(255)),
                                  eos: 1'($urandom_range(1))});
        made++;
      end
    end
    wait_drained();
  endtask

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    for (int i = 0; i < SLOTS*SLOT_BYTES; i++) slot_mem[i] = '0;
    for (int i = 0; i < SLOTS; i++) slot_len[i] = 0;
    tail_q      = 0;
    head_q      = 0;
    count_q     = 0;
    wpos_q      = 0;
    rpos_q      = 0;
    ended_q     = 1'b0;
    commits_q   = '0;
    cap_q       = CAP_RESET;
    maxlen_q    = MAXLEN_RESET;
    fail_count  = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rx_hold     = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.mode          = MODE_PUSH;
    in_ch.data_in       = '0;
    in_ch.end_of_string = 1'b0;
    out_ch.ready        = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    add_pops(1);
    add_push(8'hff, 1'b0);
    add_push(8'h01, 1'b0);
    add_push(8'h80, 1'b1);
    add_push(NUL_BYTE, 1'b1);
    add_push(8'h41, 1'b0);
    add_push(NUL_BYTE, 1'b0);
    add_push(8'h42, 1'b0);
    add_push(8'h43, 1'b1);
    add_pops(6);
    wait_drained();

    set_ring(8'd1, 8'd2);
    add_push(8'h78, 1'b0);
    add_push(8'h79, 1'b0);
    add_push(8'h7a, 1'b1);
    add_push(8'h71, 1'b0);
    add_pops(3);
    wait_drained();
    write_reg(CFG_MAX_LEN, 8'd0);
    add_push(8'h55, 1'b0);
    add_push(8'haa, 1'b1);
    add_pops(1);
    wait_drained();

    set_ring(8'd16, 8'd255);
    random_phase(450);

    set_ring(8'd3, 8'd8);
    tx_idle_pct = 83;
    random_phase(450);

    set_ring(8'd31, 8'd1);
    tx_idle_pct  = 0;
    rx_stall_pct = 83;
    random_phase(450);

    set_ring(8'd7, 8'd40);
    tx_idle_pct  = 16;
    rx_stall_pct = 16;
    random_phase(450);

    set_ring(8'd0, 8'd0);
    random_phase(150);

    set_ring(8'd16, 8'd255);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold      = 1'b1;
    for (int i = 0; i < 10; i++) add_string($urandom_range(8, 1), 1'b0);
    add_pops(20);
    repeat (300) @(negedge clk);
    rx_hold = 1'b0;
    wait_drained();

    repeat (10) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### string_slot_ring_fifo_unit.f
+incdir+hw/rtl
hw/rtl/ssrf_pkg.sv
hw/rtl/ssrf_in_if.sv
hw/rtl/ssrf_out_if.sv
hw/rtl/ssrf_ram.sv
hw/rtl/ssrf_ctrl.sv
hw/rtl/string_slot_ring_fifo_unit.sv
sim/tb_string_slot_ring_fifo_unit.sv
